@@ hdl/multi_channel_frame_deframer_top_assert.svh @@
// assertion macros for the frame deframer checker
`ifndef MULTI_CHANNEL_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define MULTI_CHANNEL_FRAME_DEFRAMER_TOP_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define MCFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication whose consequent is checked in the following cycle
`define MCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mcfd_pkg.sv @@
// shared constants and types for the multi-channel frame deframer
package mcfd_pkg;

  localparam int unsigned MCFD_MAX_LEN      = 64;
  localparam int unsigned MCFD_NUM_CHANNELS = 3;
  localparam int unsigned LEN_W             = 6;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_START_ERR   = 3'd1;
  localparam logic [2:0] ST_QOS_ERR     = 3'd2;
  localparam logic [2:0] ST_LEN_ERR     = 3'd3;
  localparam logic [2:0] ST_BAD_CHANNEL = 3'd4;

  // parser phases
  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_QOS  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_TAIL = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_HEAD        = 2'd0;
  localparam logic [1:0] REG_TAIL_FIRST  = 2'd1;
  localparam logic [1:0] REG_TAIL_SECOND = 2'd2;

  localparam logic [7:0] HEAD_RST        = 8'h3e;
  localparam logic [7:0] TAIL_FIRST_RST  = 8'h0d;
  localparam logic [7:0] TAIL_SECOND_RST = 8'h0a;

  localparam logic [7:0] QOS_CHAR_0 = 8'h30;
  localparam logic [7:0] QOS_CHAR_1 = 8'h31;

  typedef struct packed {
    logic [2:0]       status;
    logic             frame_done;
    logic [1:0]       frame_channel;
    logic [7:0]       payload_byte;
    logic             payload_valid;
    logic [LEN_W-1:0] payload_length;
    logic             ack_request;
    logic             last;
  } result_t;

endpackage

@@ hdl/mcfd_payload_ram.sv @@
// payload byte store: one write port, one registered read port
module mcfd_payload_ram
  import mcfd_pkg::*;
#(
  parameter int unsigned DEPTH = MCFD_NUM_CHANNELS * MCFD_MAX_LEN,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/multi_channel_frame_deframer_top.sv @@
// multi-channel frame deframer: per-channel parser with context and payload memories
//
//   channel  signals                                  direction
//   in       in_valid_i/in_ready_o, channel, rx_byte   sink
//   out      out_valid_o/out_ready_i, result fields    source
//   cfg      cfg_valid_i/cfg_ready_o, index, data      sink, always ready
//
// an ordinary byte: context read, then decide and write back
// a stored tail_first plus following byte makes two payload writes, the second in S_WR2
// a completed frame reads, then emits, each payload byte in turn (S_DRAIN_RD, S_DRAIN_OUT)
// reset clears the context valid bits at once, payload memory is never cleared
// the single output register stalls the sequencer while a result waits
module multi_channel_frame_deframer_top
  import mcfd_pkg::*;
#(
  parameter int unsigned MAX_LEN      = MCFD_MAX_LEN,
  parameter int unsigned NUM_CHANNELS = MCFD_NUM_CHANNELS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] channel_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic       frame_done_o,
  output logic [1:0] frame_channel_o,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic [5:0] payload_length_o,
  output logic       ack_request_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned CNT_W    = $clog2(MAX_LEN);
  localparam int unsigned CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned PL_DEPTH = NUM_CHANNELS * MAX_LEN;
  localparam int unsigned PL_AW    = $clog2(PL_DEPTH);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CTX       = 3'd1;
  localparam logic [2:0] S_WR2       = 3'd2;
  localparam logic [2:0] S_DRAIN_RD  = 3'd3;
  localparam logic [2:0] S_DRAIN_OUT = 3'd4;

  typedef struct packed {
    logic [1:0]       phase;
    logic             qos;
    logic [CNT_W-1:0] count;
  } ctx_t;

  logic [2:0] state_q, state_d;

  logic [7:0] head_q, tail_first_q, tail_second_q;

  logic [1:0]          chan_q;
  logic [7:0]          byte_q;
  logic                bad_q;
  logic [PL_AW-1:0]    base_q;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic                ack_q, ack_d;

  // context memory with valid bits, an invalid entry reads as all zero
  ctx_t                ctx_mem [NUM_CHANNELS];
  ctx_t                ctx_rd_q;
  logic                ctx_rd_v_q;
  logic [NUM_CHANNELS-1:0] ctx_vld_q;
  logic                ctx_we;
  ctx_t                ctx_wdata;
  ctx_t                ctx_cur;
  logic [CH_IDX_W-1:0] ch_in_idx, ch_idx;

  logic             pl_we, pl_re;
  logic [PL_AW-1:0] pl_waddr, pl_raddr;
  logic [7:0]       pl_wdata, pl_rdata;

  result_t out_q, res;
  logic    out_valid_q, out_load, out_free;
  logic    in_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign ch_in_idx   = CH_IDX_W'(channel_i);
  assign ch_idx      = CH_IDX_W'(chan_q);
  assign ctx_cur     = ctx_rd_v_q ? ctx_rd_q : '0;
  assign out_free    = !out_valid_q || out_ready_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q        <= HEAD_RST;
      tail_first_q  <= TAIL_FIRST_RST;
      tail_second_q <= TAIL_SECOND_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HEAD:        head_q        <= cfg_data_i;
        REG_TAIL_FIRST:  tail_first_q  <= cfg_data_i;
        REG_TAIL_SECOND: tail_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      chan_q <= channel_i;
      byte_q <= rx_byte_i;
      base_q <= PL_AW'(32'(ch_in_idx) * MAX_LEN);
    end
  end

  // context memory
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ctx_rd_q <= ctx_mem[ch_in_idx];
    end
    if (ctx_we) begin
      ctx_mem[ch_idx] <= ctx_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_vld_q  <= '0;
      ctx_rd_v_q <= 1'b0;
      bad_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        bad_q      <= (32'(channel_i) >= NUM_CHANNELS);
        ctx_rd_v_q <= (32'(channel_i) < NUM_CHANNELS) && ctx_vld_q[ch_in_idx];
      end
      if (ctx_we) begin
        ctx_vld_q[ch_idx] <= 1'b1;
      end
    end
  end

  mcfd_payload_ram #(
    .DEPTH (PL_DEPTH),
    .AW    (PL_AW)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (pl_waddr),
    .wdata_i (pl_wdata),
    .re_i    (pl_re),
    .raddr_i (pl_raddr),
    .rdata_o (pl_rdata)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    n_d       = n_q;
    ack_d     = ack_q;
    ctx_we    = 1'b0;
    ctx_wdata = ctx_cur;
    pl_we     = 1'b0;
    pl_waddr  = base_q + PL_AW'(ctx_cur.count);
    pl_wdata  = byte_q;
    pl_re     = 1'b0;
    pl_raddr  = base_q + PL_AW'(k_q);
    out_load  = 1'b0;
    res       = '0;
    res.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CTX;
        end
      end
      S_CTX: begin
        if (out_free) begin
          state_d  = S_IDLE;
          out_load = 1'b1;
          if (bad_q) begin
            res.status = ST_BAD_CHANNEL;
          end else begin
            ctx_we = 1'b1;
            unique case (ctx_cur.phase)
              PH_HEAD: begin
                if (byte_q == head_q) begin
                  ctx_wdata.phase = PH_QOS;
                end else begin
                  res.status = ST_START_ERR;
                end
              end
              PH_QOS: begin
                if (byte_q == QOS_CHAR_0 || byte_q == QOS_CHAR_1) begin
                  ctx_wdata.qos   = (byte_q == QOS_CHAR_1);
                  ctx_wdata.phase = PH_DATA;
                end else begin
                  ctx_wdata.phase = PH_HEAD;
                  res.status      = ST_QOS_ERR;
                end
              end
              PH_DATA: begin
                if (byte_q == tail_first_q) begin
                  ctx_wdata.phase = PH_TAIL;
                end else if (32'(ctx_cur.count) < MAX_LEN - 1) begin
                  pl_we           = 1'b1;
                  ctx_wdata.count = CNT_W'(ctx_cur.count + 1'b1);
                end else begin
                  ctx_wdata  = '0;
                  res.status = ST_LEN_ERR;
                end
              end
              PH_TAIL: begin
                if (byte_q == tail_second_q) begin
                  ctx_wdata = '0;
                  n_d       = ctx_cur.count;
                  ack_d     = ctx_cur.qos;
                  k_d       = '0;
                  if (ctx_cur.count == '0) begin
                    // empty frame gives a single done result
                    res.frame_done    = 1'b1;
                    res.frame_channel = chan_q;
                    res.ack_request   = ctx_cur.qos;
                  end else begin
                    out_load = 1'b0;
                    state_d  = S_DRAIN_RD;
                  end
                end else if (32'(ctx_cur.count) < MAX_LEN - 2) begin
                  // stray tail_first kept as data, the current byte follows next cycle
                  pl_we           = 1'b1;
                  pl_wdata        = tail_first_q;
                  ctx_wdata.count = CNT_W'(ctx_cur.count + 2'd2);
                  ctx_wdata.phase = PH_DATA;
                  k_d             = CNT_W'(ctx_cur.count + 1'b1);
                  state_d         = S_WR2;
                end else begin
                  ctx_wdata  = '0;
                  res.status = ST_LEN_ERR;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_WR2: begin
        pl_we    = 1'b1;
        pl_waddr = base_q + PL_AW'(k_q);
        state_d  = S_IDLE;
      end
      S_DRAIN_RD: begin
        pl_re   = 1'b1;
        state_d = S_DRAIN_OUT;
      end
      S_DRAIN_OUT: begin
        if (out_free) begin
          out_load           = 1'b1;
          res.frame_done     = 1'b1;
          res.frame_channel  = chan_q;
          res.payload_byte   = pl_rdata;
          res.payload_valid  = 1'b1;
          res.payload_length = LEN_W'(n_q);
          res.ack_request    = ack_q;
          res.last           = (k_q == CNT_W'(n_q - 1'b1));
          if (res.last) begin
            state_d = S_IDLE;
          end else begin
            k_d     = CNT_W'(k_q + 1'b1);
            state_d = S_DRAIN_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    n_q   <= n_d;
    ack_q <= ack_d;
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign frame_done_o     = out_q.frame_done;
  assign frame_channel_o  = out_q.frame_channel;
  assign payload_byte_o   = out_q.payload_byte;
  assign payload_valid_o  = out_q.payload_valid;
  assign payload_length_o = out_q.payload_length;
  assign ack_request_o    = out_q.ack_request;
  assign last_o           = out_q.last;

endmodule

@@ hdl/mcfd_checker.sv @@
// port-level checker for the frame deframer, bound to the top level
`include "multi_channel_frame_deframer_top_assert.svh"

module mcfd_checker
  import mcfd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] status_o,
  input logic       frame_done_o,
  input logic [7:0] payload_byte_o,
  input logic       payload_valid_o,
  input logic [5:0] payload_length_o,
  input logic       last_o
);

  // a stalled result holds
  `MCFD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(payload_byte_o) && $stable(last_o), "stalled result changed")

  // one item is worked on at a time
  `MCFD_ASSERT_NEXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "input taken twice in a row")

  // only a frame payload run has results that are not last
  `MCFD_ASSERT(a_run_shape, (out_valid_o && !last_o) |-> (frame_done_o && payload_valid_o && status_o == ST_OK), "non-final result outside a frame")

  // an error status never carries frame data
  `MCFD_ASSERT(a_err_clean, (out_valid_o && status_o != ST_OK) |-> (!frame_done_o && !payload_valid_o && last_o && payload_length_o == 6'd0), "error result carries frame data")

endmodule

bind multi_channel_frame_deframer_top mcfd_checker u_mcfd_checker (.*);
